// ----- rtl/gbm_path_step_assert.svh -----
// Assertion macros for the GBM path step block.
`ifndef GBM_PATH_STEP_ASSERT_SVH
`define GBM_PATH_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gbm_pkg.sv -----
// Shared constants, types and tables for the GBM path step block.
package gbm_pkg;

	localparam int PRICE_WIDTH_DEF = 48;
	localparam int PRICE_OUT_W     = 48;
	localparam int REG_IDX_W       = 2;
	localparam int WR_DATA_W       = 48;

	localparam logic [REG_IDX_W-1:0] REG_START_PRICE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOG_DRIFT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOG_DIFF    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEPS       = 2'd3;

	localparam logic [47:0] START_PRICE_RST = 48'd65536;

	// serial multiplier geometry
	localparam int DIGIT_W = 8;
	localparam int MUL_BW  = 32;
	localparam int MIN_AW  = 40;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [3:0]  SERIES_TERMS = 4'd12;

	// log increment clamp, +-64 in Q8.24
	localparam logic signed [38:0] X_LIM  = 39'sd1073741824;
	localparam logic signed [38:0] X_NLIM = -39'sd1073741824;

	// final scale: value = P << 63 >> (30 + 63 - n)
	localparam int          LSHIFT_MAX = 63;
	localparam logic [8:0]  SHIFT_BIAS = 9'd93;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_LOG2E,
		ST_LN2,
		ST_SQ,
		ST_DIV,
		ST_PRICE,
		ST_OUT
	} state_t;

	// ceil(2^36 / k): floor(v / k) == (v * recip(k)) >> 36 for v < 2^31
	function automatic logic [36:0] recip(input logic [3:0] k);
		logic [36:0] r;
		case (k)
			4'd1:    r = 37'd68719476736;
			4'd2:    r = 37'd34359738368;
			4'd3:    r = 37'd22906492246;
			4'd4:    r = 37'd17179869184;
			4'd5:    r = 37'd13743895348;
			4'd6:    r = 37'd11453246123;
			4'd7:    r = 37'd9817068106;
			4'd8:    r = 37'd8589934592;
			4'd9:    r = 37'd7635497416;
			4'd10:   r = 37'd6871947674;
			4'd11:   r = 37'd6247225158;
			4'd12:   r = 37'd5726623062;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/gbm_smul.sv -----
// Digit-serial unsigned multiplier, one 8-bit digit of b per cycle.
module gbm_smul #(
	parameter int AW = gbm_pkg::MIN_AW,
	parameter int BW = gbm_pkg::MUL_BW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [AW-1:0]  a,
	input  logic [BW-1:0]  b,
	output logic           busy,
	output logic [AW+BW-1:0] p
);
	import gbm_pkg::*;

	localparam int NDIG  = BW / DIGIT_W;
	localparam int CNT_W = $clog2(NDIG + 1);
	localparam int SW    = AW + DIGIT_W;

	logic [AW-1:0]    a_q;
	logic [AW-1:0]    hi_q;
	logic [BW-1:0]    lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    sum;

	assign sum  = SW'(hi_q) + SW'(a_q) * SW'(lo_q[DIGIT_W-1:0]);
	assign busy = (cnt_q != '0);
	assign p    = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NDIG);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// partial product shifts right one digit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy) begin
			hi_q <= sum[SW-1:DIGIT_W];
			lo_q <= {sum[DIGIT_W-1:0], lo_q[BW-1:DIGIT_W]};
		end
	end

endmodule

// ----- rtl/gbm_path_step.sv -----
// Top level: one exact GBM time step per input transaction.
// Each transaction takes 28 multiplies, run one after another.
// A new transaction is accepted only after the last one has left ST_OUT, since every step uses the single
// 8-bit-per-cycle serial multiplier (diffusion, log2e, ln2, 12 series terms with reciprocal divide, price).
// Reset: registers take their listed values, step count clears, no result pending.
`include "gbm_path_step_assert.svh"
module gbm_path_step #(
	parameter int PRICE_WIDTH = gbm_pkg::PRICE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [gbm_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [gbm_pkg::WR_DATA_W-1:0]  wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             normal_sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gbm_pkg::PRICE_OUT_W-1:0] next_price,
	output logic [15:0]                    step_number,
	output logic                           path_done
);
	import gbm_pkg::*;

	localparam int MUL_AW = (PRICE_WIDTH > MIN_AW) ? PRICE_WIDTH : MIN_AW;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int EXT_W  = MUL_PW + LSHIFT_MAX;

	// configuration
	logic [47:0] start_q;
	logic [31:0] drift_q;
	logic [31:0] diff_q;
	logic [15:0] steps_q;

	// control
	state_t state_q, state_d;
	logic   issued_q;
	logic   capture;
	logic   mul_start;
	logic   mul_busy;
	logic   out_load;
	logic [3:0]  k_q;
	logic [15:0] cnt_q;

	// datapath
	logic [MUL_AW-1:0]      mul_a;
	logic [MUL_BW-1:0]      mul_b;
	logic [MUL_PW-1:0]      mul_p;
	logic [15:0]            z_q;
	logic                   sneg_q;
	logic [PRICE_WIDTH-1:0] price_q;
	logic [PRICE_WIDTH-1:0] cur_q;
	logic [PRICE_WIDTH-1:0] res_q;
	logic [15:0]            num_q;
	logic                   done_q;
	logic signed [31:0]     x_q;
	logic [7:0]             n_q;
	logic [23:0]            f_q;
	logic [29:0]            u_q;
	logic [30:0]            term_q;
	logic [31:0]            m_q;

	logic [15:0]            zmag;
	logic [48:0]            dmag, dsig;
	logic signed [38:0]     xs;
	logic signed [31:0]     xc;
	logic [30:0]            xmag;
	logic [61:0]            tmag, tsig;
	logic [8:0]             amt9;
	logic [EXT_W-1:0]       shifted;
	logic [PRICE_WIDTH-1:0] res;
	logic [15:0]            limit;
	logic [15:0]            num_n;

	// step bookkeeping at accept
	assign limit = (steps_q == '0) ? 16'd1 : steps_q;
	assign num_n = cnt_q + 16'd1;

	// d = floor(diff * z / 2^12), x = drift + d clamped
	assign zmag = z_q[15] ? (16'd0 - z_q) : z_q;
	assign dmag = {1'b0, mul_p[47:0]};
	assign dsig = sneg_q ? (49'd0 - dmag) : dmag;
	assign xs   = $signed({{7{drift_q[31]}}, drift_q}) + $signed({{2{dsig[48]}}, dsig[48:12]});
	assign xc   = (xs > X_LIM) ? 32'sh4000_0000 :
	              (xs < X_NLIM) ? -32'sh4000_0000 : xs[31:0];
	assign xmag = x_q[31] ? 31'(32'd0 - x_q) : x_q[30:0];

	// t = floor(x * log2e / 2^30)
	assign tmag = {1'b0, mul_p[60:0]};
	assign tsig = sneg_q ? (62'd0 - tmag) : tmag;

	// price * m * 2^(n - 30), saturating
	assign amt9    = SHIFT_BIAS - {n_q[7], n_q};
	assign shifted = {mul_p, {LSHIFT_MAX{1'b0}}} >> amt9[7:0];
	assign res     = (|shifted[EXT_W-1:PRICE_WIDTH]) ? '1 : shifted[PRICE_WIDTH-1:0];

	assign capture = issued_q && !mul_busy;

	gbm_smul #(
		.AW (MUL_AW),
		.BW (MUL_BW)
	) u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		out_load = 1'b0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIFF;
			end
			ST_DIFF: begin
				mul_a = MUL_AW'(diff_q);
				mul_b = MUL_BW'(zmag);
				if (capture) state_d = ST_LOG2E;
			end
			ST_LOG2E: begin
				mul_a = MUL_AW'(LOG2E_Q30);
				mul_b = MUL_BW'(xmag);
				if (capture) state_d = ST_LN2;
			end
			ST_LN2: begin
				mul_a = MUL_AW'(LN2_Q30);
				mul_b = MUL_BW'(f_q);
				if (capture) state_d = ST_SQ;
			end
			ST_SQ: begin
				mul_a = MUL_AW'(term_q);
				mul_b = MUL_BW'(u_q);
				if (capture) state_d = ST_DIV;
			end
			ST_DIV: begin
				mul_a = MUL_AW'(recip(k_q));
				mul_b = MUL_BW'(term_q);
				if (capture) state_d = (k_q == SERIES_TERMS) ? ST_PRICE : ST_SQ;
			end
			ST_PRICE: begin
				mul_a = MUL_AW'(price_q);
				mul_b = m_q;
				if (capture) state_d = ST_OUT;
			end
			ST_OUT: begin
				out_load = !out_valid || !out_stall;
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		mul_start = (state_q != ST_IDLE) && (state_q != ST_OUT) && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issued_q  <= 1'b0;
			k_q       <= 4'd1;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			start_q   <= START_PRICE_RST;
			drift_q   <= '0;
			diff_q    <= '0;
			steps_q   <= 16'd1;
		end else begin
			state_q <= state_d;
			if (capture) begin
				issued_q <= 1'b0;
			end else if (mul_start) begin
				issued_q <= 1'b1;
			end
			if (capture && state_q == ST_LN2) k_q <= 4'd1;
			if (capture && state_q == ST_DIV && k_q != SERIES_TERMS) k_q <= k_q + 4'd1;
			if (capture && state_q == ST_PRICE) cnt_q <= done_q ? 16'd0 : num_q;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (wr_en) begin
				case (wr_index)
					REG_START_PRICE: start_q <= wr_data[47:0];
					REG_LOG_DRIFT:   drift_q <= wr_data[31:0];
					REG_LOG_DIFF:    diff_q  <= wr_data[31:0];
					REG_STEPS:       steps_q <= wr_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			z_q     <= normal_sample;
			sneg_q  <= normal_sample[15];
			price_q <= (cnt_q == '0) ? PRICE_WIDTH'(start_q) : cur_q;
			num_q   <= num_n;
			done_q  <= (num_n >= limit) || (num_n == '0);
		end
		if (capture) begin
			case (state_q)
				ST_DIFF: begin
					x_q    <= xc;
					sneg_q <= xc[31];
				end
				ST_LOG2E: begin
					n_q <= tsig[61:54];
					f_q <= tsig[53:30];
				end
				ST_LN2: begin
					u_q    <= mul_p[53:24];
					term_q <= ONE_Q30;
					m_q    <= 32'(ONE_Q30);
				end
				ST_SQ: term_q <= mul_p[60:30];
				ST_DIV: begin
					term_q <= mul_p[66:36];
					m_q    <= m_q + 32'(mul_p[66:36]);
				end
				ST_PRICE: begin
					res_q <= res;
					cur_q <= res;
				end
				default: ;
			endcase
		end
		if (out_load) begin
			next_price  <= PRICE_OUT_W'(res_q);
			step_number <= num_q;
			path_done   <= done_q;
		end
	end

	`GBM_ASSERT_NOW(a_mul_no_restart, mul_start, !mul_busy, "multiplier started while busy")
	`GBM_ASSERT_NOW(a_series_range, 1'b1, (k_q >= 4'd1) && (k_q <= SERIES_TERMS), "series index out of range")
	`GBM_ASSERT_NEXT(a_step_count, out_load, out_valid && (path_done ? (cnt_q == 16'd0) : (cnt_q == step_number)), "step count disagrees with result")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for gbm_path_step: directed table, then randomized phases.
module tb_top;
	import gbm_pkg::*;

	typedef struct packed {
		logic [47:0] price;
		logic [15:0] step;
		logic        done;
	} step_res_t;

	typedef struct packed {
		bit                 is_cfg;
		logic [REG_IDX_W-1:0] idx;
		logic [47:0]        data;
		logic signed [15:0] z;
		bit                 has_exp;
		step_res_t          res;
	} stim_row_t;

	localparam logic [47:0] PMAX = 48'hFFFF_FFFF_FFFF;
	localparam step_res_t NO_RES = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [WR_DATA_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] normal_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PRICE_OUT_W-1:0] next_price;
	logic [15:0] step_number;
	logic path_done;

	// typed expectation that rides along with the current input transaction
	bit        typed_has = 1'b0;
	step_res_t typed_res = '0;

	// predictor copy of registers and path state
	logic [47:0]        cur_start = START_PRICE_RST;
	logic signed [31:0] cur_drift = '0;
	logic [31:0]        cur_diff = '0;
	logic [15:0]        cur_steps = 16'd1;
	logic [47:0]        path_price = START_PRICE_RST;
	logic [15:0]        path_steps_done = '0;

	step_res_t pending_steps[$];
	int mismatches = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	gbm_path_step uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// price * exp(log_drift + log_diffusion*z), fixed point, saturating
	function automatic logic [47:0] gbm_next_price(input logic [47:0] price,
			input logic signed [15:0] z);
		longint x, t, n, f;
		longint unsigned u, m, term;
		logic [255:0] v;
		longint s;
		x = longint'(cur_drift) + ((longint'(cur_diff) * longint'(z)) >>> 12);
		if (x > (64'sd64 <<< 24)) x = 64'sd64 <<< 24;
		if (x < -(64'sd64 <<< 24)) x = -(64'sd64 <<< 24);
		t = (x * 64'sd1549082005) >>> 30;
		n = t >>> 24;
		f = t - (n <<< 24);
		u = (longint'(f) * 64'd744261118) >> 24;
		m = 64'd1 << 30;
		term = m;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * u) >> 30) / k;
			m += term;
		end
		v = 256'(price) * 256'(m);
		s = 30 - n;
		if (s >= 0)
			v = v >> s;
		else
			v = v << (-s);
		if (v > 256'(PMAX))
			return PMAX;
		return v[47:0];
	endfunction

	function automatic step_res_t advance_path(input logic signed [15:0] z);
		step_res_t r;
		logic [47:0] p;
		logic [15:0] lim;
		p = (path_steps_done == 0) ? cur_start : path_price;
		lim = (cur_steps == 0) ? 16'd1 : cur_steps;
		r.step = path_steps_done + 16'd1;
		r.done = (r.step >= lim) || (r.step == 0);
		r.price = gbm_next_price(p, z);
		path_price = r.price;
		path_steps_done = r.done ? 16'd0 : r.step;
		return r;
	endfunction

	// register writes and input transactions update the predictor
	always @(posedge clk) begin
		step_res_t r;
		if (wr_en) begin
			case (wr_index)
				REG_START_PRICE: cur_start = wr_data[47:0];
				REG_LOG_DRIFT:   cur_drift = wr_data[31:0];
				REG_LOG_DIFF:    cur_diff = wr_data[31:0];
				REG_STEPS:       cur_steps = wr_data[15:0];
				default: ;
			endcase
		end
		if (arst_n && in_valid && !in_stall) begin
			r = advance_path(normal_sample);
			pending_steps.push_back(typed_has ? typed_res : r);
		end
	end

	// result checker
	always @(posedge clk) begin
		step_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_steps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result price=%0d step=%0d done=%0b",
						next_price, step_number, path_done);
			end else begin
				e = pending_steps.pop_front();
				if (next_price !== e.price || step_number !== e.step ||
						path_done !== e.done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp price=%0d step=%0d done=%0b, got %0d %0d %0b",
							e.price, e.step, e.done, next_price, step_number, path_done);
				end
			end
		end
	end

	// receiver: random stall plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_req = 1'b0;
			hold_left = 2000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	task automatic send_sample(input logic signed [15:0] z, input bit has,
			input step_res_t res);
		int gap;
		gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 250) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		normal_sample <= z;
		typed_has <= has;
		typed_res <= res;
		do @(posedge clk); while (in_stall);
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [47:0] data);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	stim_row_t dir_tab[] = '{
		'{0, REG_START_PRICE, 48'd0, 16'sh7fff, 1, '{48'd65536, 16'd1, 1'b1}},
		'{1, REG_LOG_DIFF, 48'hFFFF_FFFF, 16'sd0, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sh7fff, 1, '{PMAX, 16'd1, 1'b1}},
		'{0, REG_START_PRICE, 48'd0, -16'sd32768, 1, '{48'd0, 16'd1, 1'b1}},
		'{1, REG_START_PRICE, 48'd0, 16'sd0, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sh7fff, 1, '{48'd0, 16'd1, 1'b1}},
		'{1, REG_START_PRICE, PMAX, 16'sd0, 0, NO_RES},
		'{1, REG_LOG_DIFF, 48'd0, 16'sd0, 0, NO_RES},
		'{1, REG_LOG_DRIFT, 48'h7FFF_FFFF, 16'sd0, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sd0, 1, '{PMAX, 16'd1, 1'b1}},
		'{1, REG_LOG_DRIFT, 48'h8000_0000, 16'sd0, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sd0, 1, '{48'd0, 16'd1, 1'b1}},
		'{1, REG_START_PRICE, 48'd6553600, 16'sd0, 0, NO_RES},
		'{1, REG_LOG_DRIFT, 48'h0000_1000, 16'sd0, 0, NO_RES},
		'{1, REG_LOG_DIFF, 48'h0040_0000, 16'sd0, 0, NO_RES},
		'{1, REG_STEPS, 48'd0, 16'sd0, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sh1234, 0, NO_RES},
		'{1, REG_STEPS, 48'd10, 16'sd0, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sh0abc, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, -16'sd4096, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sh5a5a, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, -16'sd21846, 0, NO_RES},
		'{1, REG_STEPS, 48'd3, 16'sd0, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, 16'sd100, 0, NO_RES},
		'{0, REG_START_PRICE, 48'd0, -16'sd100, 0, NO_RES}
	};

	initial begin
		logic [47:0] sp;
		logic [15:0] ns;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				send_sample(dir_tab[i].z, dir_tab[i].has_exp, dir_tab[i].res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 57; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 57; end
				default: begin snd_idle_pct = 37; rcv_stall_pct = 37; end
			endcase
			case (ph)
				3: sp = 48'd0;
				6: sp = PMAX;
				default: sp = 48'(($urandom_range(1, 1000)) << 16) | 48'($urandom_range(65535));
			endcase
			case (ph)
				0: ns = 16'hFFFF;
				5: ns = 16'd0;
				default: ns = 16'($urandom_range(1, 30));
			endcase
			write_reg(REG_START_PRICE, sp);
			write_reg(REG_LOG_DRIFT, 48'(32'($signed($urandom_range(0, 1 << 21)) - (1 << 20))));
			write_reg(REG_LOG_DIFF, (ph == 7) ? 48'hFFFF_FFFF : 48'($urandom_range(1 << 23)));
			write_reg(REG_STEPS, 48'(ns));
			for (int i = 0; i < 240; i++) begin
				if (ph == 1 && i == 40)
					hold_req = 1'b1;
				send_sample(16'($urandom_range(16'hFFFF)), 1'b0, NO_RES);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#40000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
